// ----- rtl/cet_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cet_pkg;

  localparam int unsigned TableEntriesDef = 64;
  localparam int unsigned CmdW            = 2;
  localparam int unsigned FamilyW         = 2;
  localparam int unsigned ValueW          = 32;
  localparam int unsigned KeyW            = FamilyW + ValueW;
  localparam int unsigned CountW          = 32;
  localparam int unsigned IntervalW       = 16;
  localparam int unsigned ElapsedW        = 32;

  localparam logic [IntervalW-1:0] IntervalReset = IntervalW'(1000);
  localparam logic [CountW-1:0]    CountMax      = '1;
  localparam logic [ElapsedW-1:0]  ElapsedMax    = '1;

  typedef enum logic [CmdW-1:0] {
    CMD_RECORD = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_REFILL
  } state_e;

  typedef struct packed {
    logic            shift;
    logic            bump;
    logic            insert;
    logic [KeyW-1:0] key;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/cet_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cet_cell (
  input  wire logic                       clk_i,
  input  wire cet_pkg::cell_ctl_t         ctl_i,
  input  wire logic                       occupied_i,
  input  wire logic                       ins_sel_i,
  input  wire logic [cet_pkg::KeyW-1:0]   nxt_key_i,
  input  wire logic [cet_pkg::CountW-1:0] nxt_count_i,
  output logic      [cet_pkg::KeyW-1:0]   key_o,
  output logic      [cet_pkg::CountW-1:0] count_o,
  output logic                            hit_o
);
  import cet_pkg::*;

  logic [KeyW-1:0]   key_q, key_d;
  logic [CountW-1:0] count_q, count_d;

  assign hit_o   = occupied_i && (key_q == ctl_i.key);
  assign key_o   = key_q;
  assign count_o = count_q;

  always_comb begin
    key_d   = key_q;
    count_d = count_q;
    if (ctl_i.shift) begin
      key_d   = nxt_key_i;
      count_d = nxt_count_i;
    end else if (ctl_i.bump && hit_o) begin
      if (count_q != CountMax) begin
        count_d = count_q + CountW'(1);
      end
    end else if (ctl_i.insert && ins_sel_i) begin
      key_d   = ctl_i.key;
      count_d = CountW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    count_q <= count_d;
  end

endmodule

`default_nettype wire

// ----- rtl/coalescing_event_tally_top.sv -----
// Event tally with coalescing of repeated keys.
// The input channel carries one command per beat: record an event (family and
// value), a one millisecond tick, or a flush request. The output channel
// carries flushed entries, oldest first, with last_o marking the final one.
// A record, a tick, or a flush of an empty table is accepted while idle; a
// record finding the flush interval spent also starts a flush. The table is
// a chain of cells that all compare the key at once; a flush shifts the chain
// toward the output, one entry per cycle while the receiver does not stall,
// the first beat appearing the cycle after the trigger. A flush thus holds
// the input stalled until its final entry is taken. A record that misses on
// a full table first drains all TABLE_ENTRIES entries, then inserts its key.
// While the receiver stalls, the front entry stays on the output unchanged.
// Reset empties the table, clears the millisecond counter, unseeds the clock
// and sets the flush interval to 1000. The user must write the interval
// register by cfg_we_i only while the block is idle; this is not enforced.
`timescale 1ns / 1ps
`default_nettype none

module coalescing_event_tally_top #(
  parameter int unsigned TABLE_ENTRIES = cet_pkg::TableEntriesDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [cet_pkg::IntervalW-1:0] cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [cet_pkg::CmdW-1:0]      command_i,
  input  wire logic [cet_pkg::FamilyW-1:0]   family_i,
  input  wire logic [cet_pkg::ValueW-1:0]    value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [cet_pkg::FamilyW-1:0]   out_family_o,
  output logic      [cet_pkg::ValueW-1:0]    out_value_o,
  output logic      [cet_pkg::CountW-1:0]    out_count_o,
  output logic                               last_o
);
  import cet_pkg::*;

  localparam int unsigned UsedW = $clog2(TABLE_ENTRIES + 1);

  state_e state_q, state_d;
  logic [UsedW-1:0]     used_q, used_d;
  logic [ElapsedW-1:0]  elapsed_q, elapsed_d;
  logic                 seeded_q, seeded_d;
  logic                 pend_q, pend_d;
  logic [KeyW-1:0]      pend_key_q, pend_key_d;
  logic [IntervalW-1:0] interval_q;

  cell_ctl_t          ctl;
  logic [KeyW-1:0]    key_w   [TABLE_ENTRIES];
  logic [CountW-1:0]  count_w [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] hit_w;

  logic                 in_acc, out_acc, is_rec, is_tick, is_flush;
  logic                 found, full, need_cap, timed, drain_done;
  logic [IntervalW-1:0] limit;
  logic [KeyW-1:0]      in_key;

  assign in_key     = {family_i, value_i};
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;
  assign is_rec     = in_acc && (command_i == CMD_RECORD);
  assign is_tick    = in_acc && (command_i == CMD_TICK);
  assign is_flush   = in_acc && (command_i == CMD_FLUSH);
  assign found      = |hit_w;
  assign full       = (used_q == UsedW'(TABLE_ENTRIES));
  assign limit      = (interval_q == '0) ? IntervalW'(1) : interval_q;
  assign need_cap   = is_rec && !found && full;
  assign timed      = is_rec && !need_cap && seeded_q &&
                      (elapsed_q >= ElapsedW'(limit));
  assign drain_done = out_acc && (used_q == UsedW'(1));

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    logic [KeyW-1:0]   nxt_key;
    logic [CountW-1:0] nxt_count;
    if (i == TABLE_ENTRIES - 1) begin : g_end
      assign nxt_key   = key_w[i];
      assign nxt_count = count_w[i];
    end else begin : g_mid
      assign nxt_key   = key_w[i+1];
      assign nxt_count = count_w[i+1];
    end
    cet_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .occupied_i  (UsedW'(i) < used_q),
      .ins_sel_i   (UsedW'(i) == used_q),
      .nxt_key_i   (nxt_key),
      .nxt_count_i (nxt_count),
      .key_o       (key_w[i]),
      .count_o     (count_w[i]),
      .hit_o       (hit_w[i])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (need_cap || timed || (is_flush && used_q != '0)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_done) begin
          state_d = pend_q ? ST_REFILL : ST_IDLE;
        end
      end
      ST_REFILL: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o   = (state_q != ST_IDLE);
    out_valid_o  = (state_q == ST_DRAIN);
    out_family_o = key_w[0][KeyW-1:ValueW];
    out_value_o  = key_w[0][ValueW-1:0];
    out_count_o  = count_w[0];
    last_o       = (used_q == UsedW'(1));
    ctl.shift    = out_acc;
    ctl.bump     = is_rec;
    ctl.insert   = (is_rec && !found && !full) || (state_q == ST_REFILL);
    ctl.key      = (state_q == ST_REFILL) ? pend_key_q : in_key;
  end

  always_comb begin
    used_d     = used_q;
    elapsed_d  = elapsed_q;
    seeded_d   = seeded_q;
    pend_d     = pend_q;
    pend_key_d = pend_key_q;
    if (ctl.shift) begin
      used_d = used_q - UsedW'(1);
    end else if (ctl.insert) begin
      used_d = used_q + UsedW'(1);
    end
    if (need_cap) begin
      pend_d     = 1'b1;
      pend_key_d = in_key;
    end else if (state_q == ST_REFILL) begin
      pend_d = 1'b0;
    end
    if (is_tick) begin
      if (elapsed_q != ElapsedMax) begin
        elapsed_d = elapsed_q + ElapsedW'(1);
      end
    end else if ((is_flush && used_q == '0) || drain_done) begin
      elapsed_d = '0;
      seeded_d  = 1'b1;
    end else if (is_rec && !need_cap && !seeded_q) begin
      elapsed_d = '0;
      seeded_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      used_q     <= '0;
      elapsed_q  <= '0;
      seeded_q   <= 1'b0;
      pend_q     <= 1'b0;
      interval_q <= IntervalReset;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      elapsed_q <= elapsed_d;
      seeded_q  <= seeded_d;
      pend_q    <= pend_d;
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_key_q <= pend_key_d;
  end

  // Keys in the table are distinct, so at most one cell can match.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(hit_w))
    else $error("More than one cell matched the key.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (used_q != '0))
    else $error("Output beat offered from an empty table.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_o) |=> (used_q == '0))
    else $error("Table not empty after the final beat of a flush.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UsedW'(TABLE_ENTRIES))
    else $error("Entry count exceeds the table size.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REFILL) |-> (pend_q && used_q == '0))
    else $error("Refill without a pending key or with a non-empty table.");

endmodule

`default_nettype wire
